>>> rtl/core/mit_command_frame_encoder_top_defines.svh
// Assertion macros for the motor command frame encoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MIT_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH
`define MIT_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MCFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcfe check failed");

// Next-cycle implication, checked out of reset.
`define MCFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcfe check failed");

`endif

>>> rtl/core/mcfe_pkg.sv
// Shared types and constants of the motor command frame encoder.
// No dependencies.
package mcfe_pkg;

  localparam int POS_CODE_W  = 16;
  localparam int GAIN_CODE_W = 12;
  localparam int VAL_W       = 17;
  localparam int RNG_W       = 16;
  localparam int DIV_STEPS   = RNG_W;
  localparam int LANE_STAGES = DIV_STEPS + 2;
  localparam int ID_W        = 11;
  localparam int LIM_W       = 15;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int PAYLOAD_W   = 64;
  localparam int NUM_LANES   = 5;

  localparam int MODE_ID_OFFSET_DEF = 0;

  localparam logic [ID_W-1:0]  BASE_ID_RST      = 11'd1;
  localparam logic [LIM_W-1:0] POS_LIMIT_RST    = 15'd12800;
  localparam logic [LIM_W-1:0] VEL_LIMIT_RST    = 15'd1920;
  localparam logic [LIM_W-1:0] TORQUE_LIMIT_RST = 15'd640;
  localparam logic [LIM_W-1:0] STIFF_LOW_RST    = 15'd0;
  localparam logic [LIM_W-1:0] STIFF_HIGH_RST   = 15'd32000;
  localparam logic [LIM_W-1:0] DAMP_LOW_RST     = 15'd0;
  localparam logic [LIM_W-1:0] DAMP_HIGH_RST    = 15'd20480;

  typedef enum logic [2:0] {
    REG_BASE_ID      = 3'd0,
    REG_POS_LIMIT    = 3'd1,
    REG_VEL_LIMIT    = 3'd2,
    REG_TORQUE_LIMIT = 3'd3,
    REG_STIFF_LOW    = 3'd4,
    REG_STIFF_HIGH   = 3'd5,
    REG_DAMP_LOW     = 3'd6,
    REG_DAMP_HIGH    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]  base_id;
    logic [LIM_W-1:0] pos_limit;
    logic [LIM_W-1:0] vel_limit;
    logic [LIM_W-1:0] torque_limit;
    logic [LIM_W-1:0] stiff_low;
    logic [LIM_W-1:0] stiff_high;
    logic [LIM_W-1:0] damp_low;
    logic [LIM_W-1:0] damp_high;
  } cfg_t;

endpackage

>>> rtl/core/mcfe_cfg.sv
// APB register file of the motor command frame encoder.
// Depends on mcfe_pkg.
module mcfe_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcfe_pkg::ADDR_W-1:0] paddr,
  input  logic [mcfe_pkg::DATA_W-1:0] pwdata,
  output logic [mcfe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mcfe_pkg::cfg_t              cfg
);

  mcfe_pkg::cfg_t   cfg_r;
  mcfe_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = mcfe_pkg::reg_idx_t'(paddr[mcfe_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id      <= mcfe_pkg::BASE_ID_RST;
      cfg_r.pos_limit    <= mcfe_pkg::POS_LIMIT_RST;
      cfg_r.vel_limit    <= mcfe_pkg::VEL_LIMIT_RST;
      cfg_r.torque_limit <= mcfe_pkg::TORQUE_LIMIT_RST;
      cfg_r.stiff_low    <= mcfe_pkg::STIFF_LOW_RST;
      cfg_r.stiff_high   <= mcfe_pkg::STIFF_HIGH_RST;
      cfg_r.damp_low     <= mcfe_pkg::DAMP_LOW_RST;
      cfg_r.damp_high    <= mcfe_pkg::DAMP_HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        mcfe_pkg::REG_BASE_ID:      cfg_r.base_id      <= pwdata[mcfe_pkg::ID_W-1:0];
        mcfe_pkg::REG_POS_LIMIT:    cfg_r.pos_limit    <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_VEL_LIMIT:    cfg_r.vel_limit    <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_TORQUE_LIMIT: cfg_r.torque_limit <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_STIFF_LOW:    cfg_r.stiff_low    <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_STIFF_HIGH:   cfg_r.stiff_high   <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_DAMP_LOW:     cfg_r.damp_low     <= pwdata[mcfe_pkg::LIM_W-1:0];
        mcfe_pkg::REG_DAMP_HIGH:    cfg_r.damp_high    <= pwdata[mcfe_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      mcfe_pkg::REG_BASE_ID:      prdata = mcfe_pkg::DATA_W'(cfg_r.base_id);
      mcfe_pkg::REG_POS_LIMIT:    prdata = mcfe_pkg::DATA_W'(cfg_r.pos_limit);
      mcfe_pkg::REG_VEL_LIMIT:    prdata = mcfe_pkg::DATA_W'(cfg_r.vel_limit);
      mcfe_pkg::REG_TORQUE_LIMIT: prdata = mcfe_pkg::DATA_W'(cfg_r.torque_limit);
      mcfe_pkg::REG_STIFF_LOW:    prdata = mcfe_pkg::DATA_W'(cfg_r.stiff_low);
      mcfe_pkg::REG_STIFF_HIGH:   prdata = mcfe_pkg::DATA_W'(cfg_r.stiff_high);
      mcfe_pkg::REG_DAMP_LOW:     prdata = mcfe_pkg::DATA_W'(cfg_r.damp_low);
      mcfe_pkg::REG_DAMP_HIGH:    prdata = mcfe_pkg::DATA_W'(cfg_r.damp_high);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/mcfe_lane.sv
// One encoding lane: range check, scale by the code span, pipelined divide.
// Depends on mcfe_pkg.
module mcfe_lane #(
  parameter int CODE_W = mcfe_pkg::GAIN_CODE_W
) (
  input  logic                              clk,
  input  logic [mcfe_pkg::LANE_STAGES-1:0]  en,
  input  logic signed [mcfe_pkg::VAL_W-1:0] x,
  input  logic signed [mcfe_pkg::VAL_W-1:0] lo,
  input  logic signed [mcfe_pkg::VAL_W-1:0] hi,
  output logic [CODE_W-1:0]                 code,
  output logic                              clip
);

  localparam int RW = mcfe_pkg::RNG_W;
  localparam int NS = mcfe_pkg::LANE_STAGES;
  localparam int DS = mcfe_pkg::DIV_STEPS;
  localparam logic [RW-1:0] FULL = RW'((64'd1 << CODE_W) - 64'd1);

  logic signed [mcfe_pkg::VAL_W-1:0] ofs_c;
  logic signed [mcfe_pkg::VAL_W-1:0] rng_c;
  logic [RW-1:0]   ofs0_r;
  logic [2*RW-1:0] prod1_r;
  logic [2*RW-1:0] w_r [DS];
  logic [RW-1:0]   d_r [NS-1];
  logic            z_r [NS];
  logic            o_r [NS];
  logic [2*RW-1:0] w_in [DS];
  logic [2*RW-1:0] w_nxt [DS];
  logic [RW:0]     t [DS];
  logic [RW:0]     dif [DS];
  logic            ge [DS];

  assign ofs_c = x - lo;
  assign rng_c = hi - lo;

  always_comb begin
    for (int k = 0; k < DS; k++) begin
      w_in[k]  = (k == 0) ? prod1_r : w_r[(k == 0) ? 0 : k-1];
      t[k]     = w_in[k][2*RW-1 -: RW+1];
      ge[k]    = t[k] >= {1'b0, d_r[k+1]};
      dif[k]   = t[k] - {1'b0, d_r[k+1]};
      w_nxt[k] = {(ge[k] ? dif[k][RW-1:0] : t[k][RW-1:0]), w_in[k][RW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ofs0_r <= ofs_c[RW-1:0];
      d_r[0] <= rng_c[RW-1:0];
      z_r[0] <= (hi <= lo) || (x < lo);
      o_r[0] <= x > hi;
    end
    if (en[1]) begin
      prod1_r <= (2*RW)'(ofs0_r) * (2*RW)'(FULL);
      d_r[1]  <= d_r[0];
      z_r[1]  <= z_r[0];
      o_r[1]  <= o_r[0];
    end
    for (int k = 0; k < DS; k++) begin
      if (en[k+2]) begin
        w_r[k]   <= w_nxt[k];
        z_r[k+2] <= z_r[k+1];
        o_r[k+2] <= o_r[k+1];
      end
    end
    for (int k = 0; k < DS - 1; k++) begin
      if (en[k+2]) begin
        d_r[k+2] <= d_r[k+1];
      end
    end
  end

  assign clip = z_r[NS-1] || o_r[NS-1];

  always_comb begin
    if (z_r[NS-1]) begin
      code = '0;
    end else if (o_r[NS-1]) begin
      code = FULL[CODE_W-1:0];
    end else begin
      code = w_r[DS-1][CODE_W-1:0];
    end
  end

endmodule

>>> rtl/core/mcfe_merge.sv
// Merge stage: packs lane codes into the frame and holds the result register.
// Depends on mcfe_pkg.
module mcfe_merge #(
  parameter int MODE_ID_OFFSET = mcfe_pkg::MODE_ID_OFFSET_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                lane_valid,
  input  logic [mcfe_pkg::ID_W-1:0]           base_id,
  input  logic [mcfe_pkg::POS_CODE_W-1:0]     pos_code,
  input  logic [mcfe_pkg::GAIN_CODE_W-1:0]    vel_code,
  input  logic [mcfe_pkg::GAIN_CODE_W-1:0]    kp_code,
  input  logic [mcfe_pkg::GAIN_CODE_W-1:0]    kd_code,
  input  logic [mcfe_pkg::GAIN_CODE_W-1:0]    tq_code,
  input  logic [mcfe_pkg::NUM_LANES-1:0]      lane_clip,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcfe_pkg::ID_W-1:0]           out_can_id,
  output logic [mcfe_pkg::PAYLOAD_W-1:0]      out_payload,
  output logic                                out_clipped
);

  logic                           out_valid_r;
  logic [mcfe_pkg::ID_W-1:0]      can_id_r;
  logic [mcfe_pkg::PAYLOAD_W-1:0] payload_r;
  logic                           clipped_r;

  assign take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      can_id_r  <= base_id + mcfe_pkg::ID_W'(MODE_ID_OFFSET);
      payload_r <= {pos_code, vel_code, kp_code, kd_code, tq_code};
      clipped_r <= |lane_clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_can_id  = can_id_r;
  assign out_payload = payload_r;
  assign out_clipped = clipped_r;

endmodule

>>> rtl/core/mit_command_frame_encoder_top.sv
// Motor command frame encoder, top level.
// Depends on mcfe_pkg, mcfe_cfg, mcfe_lane, mcfe_merge and the defines header.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command: position, velocity,
//   stiffness, damping and torque. Result channel (out_valid/out_ready) gives
//   the CAN identifier, the 64-bit payload and a clip flag, one per command.
//   Five lanes encode the setpoints side by side; each lane runs a range
//   check, a multiply by the code span and a 16-step pipelined restoring
//   divide by the range width. The merge stage packs the codes.
//   Throughput: one command per cycle while the output is not stalled; the
//   divider pipeline sets the latency.
//   Stall: stages advance only when the next one is free, so bubbles collapse
//   and in_ready stays high until every stage and the output register are full.
//   Reset (rst_n, synchronous): all stages and the output are emptied and the
//   registers take their reset values. APB writes take effect at once; write
//   them only while no command is in flight.
`include "mit_command_frame_encoder_top_defines.svh"

module mit_command_frame_encoder_top #(
  parameter int MODE_ID_OFFSET = mcfe_pkg::MODE_ID_OFFSET_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcfe_pkg::ADDR_W-1:0]      paddr,
  input  logic [mcfe_pkg::DATA_W-1:0]      pwdata,
  output logic [mcfe_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_position,
  input  logic signed [15:0]               in_velocity,
  input  logic [14:0]                      in_stiffness,
  input  logic [14:0]                      in_damping,
  input  logic signed [15:0]               in_torque,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mcfe_pkg::ID_W-1:0]        out_can_id,
  output logic [mcfe_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic                             out_clipped
);

  localparam int NS = mcfe_pkg::LANE_STAGES;
  localparam int VW = mcfe_pkg::VAL_W;

  mcfe_pkg::cfg_t cfg;
  logic [NS-1:0]  vld_r;
  logic [NS:0]    en;
  logic           take;

  logic signed [VW-1:0] pos_x, pos_hi, pos_lo;
  logic signed [VW-1:0] vel_x, vel_hi, vel_lo;
  logic signed [VW-1:0] tq_x, tq_hi, tq_lo;
  logic signed [VW-1:0] kp_x, kp_hi, kp_lo;
  logic signed [VW-1:0] kd_x, kd_hi, kd_lo;

  logic [mcfe_pkg::POS_CODE_W-1:0]  pos_code;
  logic [mcfe_pkg::GAIN_CODE_W-1:0] vel_code, kp_code, kd_code, tq_code;
  logic [mcfe_pkg::NUM_LANES-1:0]   lane_clip;

  mcfe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign pos_x  = {in_position[15], in_position};
  assign pos_hi = {2'b00, cfg.pos_limit};
  assign pos_lo = -pos_hi;
  assign vel_x  = {in_velocity[15], in_velocity};
  assign vel_hi = {2'b00, cfg.vel_limit};
  assign vel_lo = -vel_hi;
  assign tq_x   = {in_torque[15], in_torque};
  assign tq_hi  = {2'b00, cfg.torque_limit};
  assign tq_lo  = -tq_hi;
  assign kp_x   = {2'b00, in_stiffness};
  assign kp_hi  = {2'b00, cfg.stiff_high};
  assign kp_lo  = {2'b00, cfg.stiff_low};
  assign kd_x   = {2'b00, in_damping};
  assign kd_hi  = {2'b00, cfg.damp_high};
  assign kd_lo  = {2'b00, cfg.damp_low};

  // advance a stage when it is empty or the stage after it advances
  assign en[NS] = take;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  mcfe_lane #(.CODE_W(mcfe_pkg::POS_CODE_W)) u_lane_pos (
    .clk (clk), .en (en[NS-1:0]), .x (pos_x), .lo (pos_lo), .hi (pos_hi),
    .code (pos_code), .clip (lane_clip[0])
  );

  mcfe_lane #(.CODE_W(mcfe_pkg::GAIN_CODE_W)) u_lane_vel (
    .clk (clk), .en (en[NS-1:0]), .x (vel_x), .lo (vel_lo), .hi (vel_hi),
    .code (vel_code), .clip (lane_clip[1])
  );

  mcfe_lane #(.CODE_W(mcfe_pkg::GAIN_CODE_W)) u_lane_kp (
    .clk (clk), .en (en[NS-1:0]), .x (kp_x), .lo (kp_lo), .hi (kp_hi),
    .code (kp_code), .clip (lane_clip[2])
  );

  mcfe_lane #(.CODE_W(mcfe_pkg::GAIN_CODE_W)) u_lane_kd (
    .clk (clk), .en (en[NS-1:0]), .x (kd_x), .lo (kd_lo), .hi (kd_hi),
    .code (kd_code), .clip (lane_clip[3])
  );

  mcfe_lane #(.CODE_W(mcfe_pkg::GAIN_CODE_W)) u_lane_tq (
    .clk (clk), .en (en[NS-1:0]), .x (tq_x), .lo (tq_lo), .hi (tq_hi),
    .code (tq_code), .clip (lane_clip[4])
  );

  mcfe_merge #(.MODE_ID_OFFSET(MODE_ID_OFFSET)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .lane_valid  (vld_r[NS-1]),
    .base_id     (cfg.base_id),
    .pos_code    (pos_code),
    .vel_code    (vel_code),
    .kp_code     (kp_code),
    .kd_code     (kd_code),
    .tq_code     (tq_code),
    .lane_clip   (lane_clip),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_can_id  (out_can_id),
    .out_payload (out_payload),
    .out_clipped (out_clipped)
  );

  `MCFE_ASSERT_IMP(a_stall_from_output, !in_ready, out_valid && !out_ready)
  `MCFE_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_r[0])
  `MCFE_ASSERT_NXT(a_last_to_output, vld_r[NS-1] && take, out_valid)

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the motor command frame encoder.
// Holds a frame predictor class and the drivers for the command, frame and APB channels.
// Depends on mcfe_pkg and mit_command_frame_encoder_top.
`timescale 1ns / 100ps

module testbench;
  import mcfe_pkg::*;

  localparam int FRAME_ID_OFS = MODE_ID_OFFSET_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 40;
  localparam int RAND_PER_SETTING = 90;
  localparam int NUM_SETTINGS = 8;

  typedef struct {
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic [14:0]        stiffness;
    logic [14:0]        damping;
    logic signed [15:0] torque;
  } command_t;

  typedef struct {
    logic [ID_W-1:0]      can_id;
    logic [PAYLOAD_W-1:0] payload;
    logic                 clipped;
  } frame_t;

  class frame_ledger;
    cfg_t   regs;
    int     id_offset;
    frame_t pending_frames[$];
    int     failures;
    int     commands_seen;
    int     frames_checked;
    int     clipped_frames;

    function new(int offset);
      id_offset = offset;
      failures = 0;
      commands_seen = 0;
      frames_checked = 0;
      clipped_frames = 0;
      regs.base_id      = BASE_ID_RST;
      regs.pos_limit    = POS_LIMIT_RST;
      regs.vel_limit    = VEL_LIMIT_RST;
      regs.torque_limit = TORQUE_LIMIT_RST;
      regs.stiff_low    = STIFF_LOW_RST;
      regs.stiff_high   = STIFF_HIGH_RST;
      regs.damp_low     = DAMP_LOW_RST;
      regs.damp_high    = DAMP_HIGH_RST;
    endfunction

    function void set_register(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_BASE_ID:      regs.base_id      = value[ID_W-1:0];
        REG_POS_LIMIT:    regs.pos_limit    = value[LIM_W-1:0];
        REG_VEL_LIMIT:    regs.vel_limit    = value[LIM_W-1:0];
        REG_TORQUE_LIMIT: regs.torque_limit = value[LIM_W-1:0];
        REG_STIFF_LOW:    regs.stiff_low    = value[LIM_W-1:0];
        REG_STIFF_HIGH:   regs.stiff_high   = value[LIM_W-1:0];
        REG_DAMP_LOW:     regs.damp_low     = value[LIM_W-1:0];
        REG_DAMP_HIGH:    regs.damp_high    = value[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] map_code(longint x, longint lo, longint hi, int bits, inout bit clip);
      longint full;
      full = (longint'(1) << bits) - 1;
      if (hi <= lo || x < lo) begin
        clip = 1'b1;
        return '0;
      end
      if (x > hi) begin
        clip = 1'b1;
        return full[15:0];
      end
      return 16'(((x - lo) * full) / (hi - lo));
    endfunction

    function void note_command(command_t c);
      frame_t f;
      bit clip;
      logic [15:0] pc, vc, kpc, kdc, tc;
      clip = 1'b0;
      pc  = map_code(longint'(c.position), -longint'(regs.pos_limit),
                     longint'(regs.pos_limit), POS_CODE_W, clip);
      vc  = map_code(longint'(c.velocity), -longint'(regs.vel_limit),
                     longint'(regs.vel_limit), GAIN_CODE_W, clip);
      kpc = map_code(longint'(c.stiffness), longint'(regs.stiff_low),
                     longint'(regs.stiff_high), GAIN_CODE_W, clip);
      kdc = map_code(longint'(c.damping), longint'(regs.damp_low),
                     longint'(regs.damp_high), GAIN_CODE_W, clip);
      tc  = map_code(longint'(c.torque), -longint'(regs.torque_limit),
                     longint'(regs.torque_limit), GAIN_CODE_W, clip);
      f.can_id  = ID_W'(int'(regs.base_id) + id_offset);
      f.payload = {pc, vc[11:0], kpc[11:0], kdc[11:0], tc[11:0]};
      f.clipped = clip;
      pending_frames.push_back(f);
      commands_seen++;
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      frames_checked++;
      if (got.clipped) clipped_frames++;
      if (pending_frames.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: frame with nothing outstanding: id %h payload %h clip %b",
                   $realtime, got.can_id, got.payload, got.clipped);
        return;
      end
      want = pending_frames.pop_front();
      if (got.can_id !== want.can_id || got.payload !== want.payload ||
          got.clipped !== want.clipped) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: id %h/%h payload %h/%h clip %b/%b (expected/actual)",
                   $realtime, want.can_id, got.can_id, want.payload, got.payload,
                   want.clipped, got.clipped);
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 psel, penable, pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid, in_ready;
  logic signed [15:0]   in_position, in_velocity, in_torque;
  logic [14:0]          in_stiffness, in_damping;
  logic                 out_valid, out_ready;
  logic [ID_W-1:0]      out_can_id;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 out_clipped;

  frame_ledger board;
  bit tx_steady, rx_steady;
  int idle_cycles;
  int settings_applied;

  mit_command_frame_encoder_top #(.MODE_ID_OFFSET(FRAME_ID_OFS)) uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_position(in_position), .in_velocity(in_velocity),
    .in_stiffness(in_stiffness), .in_damping(in_damping), .in_torque(in_torque),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_can_id(out_can_id), .out_payload(out_payload), .out_clipped(out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic signed [15:0] pick_symmetric(int lim);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 2 * lim) - lim;
      6, 7: begin
        v = $urandom_range(0, 5);
        v = (v < 3) ? -lim + v - 1 : lim + v - 4;
      end
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  function automatic logic [14:0] pick_gain(int lo, int hi);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = (hi > lo) ? $urandom_range(lo, hi) : lo;
      6, 7: begin
        v = $urandom_range(0, 5);
        v = (v < 3) ? lo + v - 1 : hi + v - 4;
      end
      default: v = $urandom;
    endcase
    return 15'(v);
  endfunction

  function automatic command_t make_cmd(int p, int v, int kp, int kd, int tq);
    command_t c;
    c.position  = 16'(p);
    c.velocity  = 16'(v);
    c.stiffness = 15'(kp);
    c.damping   = 15'(kd);
    c.torque    = 16'(tq);
    return c;
  endfunction

  task automatic issue_command(command_t c);
    int gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_position  <= c.position;
    in_velocity  <= c.velocity;
    in_stiffness <= c.stiffness;
    in_damping   <= c.damping;
    in_torque    <= c.torque;
    do @(posedge clk); while (!in_ready);
    board.note_command(c);
  endtask

  task automatic cfg_write(reg_idx_t idx, int value);
    logic [DATA_W-1:0] word;
    word = ($urandom & 32'hFFFF_8000) | (value & 32'h0000_7FFF);
    if (idx == REG_BASE_ID) word = ($urandom & 32'hFFFF_F800) | (value & 32'h0000_07FF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, word);
  endtask

  task automatic apply_setting(int phase);
    int lo;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    case (phase)
      1: begin
        cfg_write(REG_BASE_ID, 0);
        cfg_write(REG_POS_LIMIT, 1);
        cfg_write(REG_VEL_LIMIT, 1);
        cfg_write(REG_TORQUE_LIMIT, 1);
        cfg_write(REG_STIFF_LOW, 0);
        cfg_write(REG_STIFF_HIGH, 1);
        cfg_write(REG_DAMP_LOW, 0);
        cfg_write(REG_DAMP_HIGH, 1);
      end
      2: begin
        cfg_write(REG_BASE_ID, 2047);
        cfg_write(REG_POS_LIMIT, 32767);
        cfg_write(REG_VEL_LIMIT, 32767);
        cfg_write(REG_TORQUE_LIMIT, 32767);
        cfg_write(REG_STIFF_LOW, 0);
        cfg_write(REG_STIFF_HIGH, 32767);
        cfg_write(REG_DAMP_LOW, 32766);
        cfg_write(REG_DAMP_HIGH, 32767);
      end
      3: begin
        cfg_write(REG_POS_LIMIT, 0);
        cfg_write(REG_VEL_LIMIT, 0);
        cfg_write(REG_TORQUE_LIMIT, 0);
        cfg_write(REG_STIFF_LOW, 100);
        cfg_write(REG_STIFF_HIGH, 100);
        cfg_write(REG_DAMP_LOW, 32767);
        cfg_write(REG_DAMP_HIGH, 200);
      end
      default: begin
        cfg_write(REG_BASE_ID, $urandom_range(0, 2047));
        cfg_write(REG_POS_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                             : $urandom_range(1, 32767));
        cfg_write(REG_VEL_LIMIT, $urandom_range(1, 32767));
        cfg_write(REG_TORQUE_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                                : $urandom_range(1, 32767));
        lo = $urandom_range(0, 16000);
        cfg_write(REG_STIFF_LOW, lo);
        cfg_write(REG_STIFF_HIGH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, lo)
                                                              : $urandom_range(lo + 1, 32767));
        lo = $urandom_range(0, 30000);
        cfg_write(REG_DAMP_LOW, lo);
        cfg_write(REG_DAMP_HIGH, $urandom_range(lo + 1, 32767));
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_random(int count);
    command_t c;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      c.position  = pick_symmetric(board.regs.pos_limit);
      c.velocity  = pick_symmetric(board.regs.vel_limit);
      c.stiffness = pick_gain(board.regs.stiff_low, board.regs.stiff_high);
      c.damping   = pick_gain(board.regs.damp_low, board.regs.damp_high);
      c.torque    = pick_symmetric(board.regs.torque_limit);
      issue_command(c);
    end
    in_valid <= 1'b0;
  endtask

  // frame sink with random stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(rx_steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_frame('{can_id: out_can_id, payload: out_payload, clipped: out_clipped});
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d frames outstanding", board.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    board = new(FRAME_ID_OFS);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settings_applied = 1;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_position = '0;
    in_velocity = '0;
    in_stiffness = '0;
    in_damping = '0;
    in_torque = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(make_cmd(0, 0, 0, 0, 0));
    issue_command(make_cmd(32767, 32767, 32767, 32767, 32767));
    issue_command(make_cmd(-32768, -32768, 0, 0, -32768));
    issue_command(make_cmd(12800, 1920, 32000, 20480, 640));
    issue_command(make_cmd(-12800, -1920, 0, 0, -640));
    issue_command(make_cmd(12801, 1921, 32001, 20481, 641));
    issue_command(make_cmd(-12801, -1921, 1, 1, -641));
    issue_command(make_cmd(12799, 1919, 31999, 20479, 639));
    issue_command(make_cmd(16'sh5555, 16'sh5555, 15'h5555, 15'h5555, 16'sh5555));
    issue_command(make_cmd(16'shAAAA, 16'shAAAA, 15'h2AAA, 15'h2AAA, 16'shAAAA));
    issue_command(make_cmd(100, -100, 16000, 10240, -1));
    issue_command(make_cmd(-1, 1, 1, 32766, 1));
    in_valid <= 1'b0;

    for (int phase = 1; phase <= NUM_SETTINGS; phase++) begin
      apply_setting(phase);
      run_random(RAND_PER_SETTING);
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d commands under %0d register settings %s",
             board.commands_seen, settings_applied,
             "(reset, minima, maxima, empty ranges, random)");
    $display("Checked %0d frames, %0d with clipping, %0d failures",
             board.frames_checked, board.clipped_frames, board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
